// ===== rtl/core/lod_grid_triangle_index_generator_core_defines.svh =====
// assertion macros for the lod grid index generator rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef LOD_GRID_TRIANGLE_INDEX_GENERATOR_CORE_DEFINES_SVH
`define LOD_GRID_TRIANGLE_INDEX_GENERATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication, clocked on clk, quiet during rst
`define LGT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, clocked on clk, quiet during rst
`define LGT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LGT_ASSERT_IMP(lbl, ante, cons, msg)
`define LGT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/lgt_pkg.sv =====
// shared types and constants for the lod grid index generator
// no dependencies; imported by every module of the block
package lgt_pkg;

  // field widths
  localparam int COORD_W = 7;
  localparam int CMP_W   = 8;
  localparam int LOD_W   = 4;
  localparam int VAL_W   = 15;
  localparam int ADDR_W  = 16;
  localparam int BC_W    = 9;
  localparam int MC_W    = 14;

  // grid geometry: border ring plus margin around the mesh
  localparam int GRID_PAD    = 5;
  localparam int MAP_ORIGIN  = 2;
  localparam int SKIP_MARGIN = 3;

  localparam logic [LOD_W-1:0] LOD_RESET = 4'd1;

  // operation codes
  localparam logic OP_MAP = 1'b0;
  localparam logic OP_TRI = 1'b1;

  // cell kind codes
  localparam logic [1:0] KIND_BORDER = 2'd0;
  localparam logic [1:0] KIND_MESH   = 2'd1;
  localparam logic [1:0] KIND_SKIP   = 2'd2;
  localparam logic [1:0] KIND_TRI    = 2'd3;

  typedef logic signed [VAL_W-1:0] vidx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // work item from the classifier to the map engine
  typedef struct packed {
    logic       is_tri;
    logic [1:0] kind;
    logic       wr;
    vidx_t      value;
    addr_t      addr_a;
    addr_t      addr_b;
    addr_t      addr_c;
    addr_t      addr_d;
  } cmd_t;

endpackage

// ===== rtl/core/lgt_mod.sv =====
// iterative remainder unit: two remainders by a shared 4-bit divisor
// restoring method, two dividend bits per cycle; uses lgt_pkg
module lgt_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [lgt_pkg::COORD_W-1:0] num_a,
  input  logic [lgt_pkg::COORD_W-1:0] num_b,
  input  logic [lgt_pkg::LOD_W-1:0]   divisor,
  output logic                        done,
  output logic [lgt_pkg::LOD_W-1:0]   rem_a,
  output logic [lgt_pkg::LOD_W-1:0]   rem_b
);
  import lgt_pkg::*;

  localparam int SH_W = CMP_W;
  localparam int STEPS = SH_W / 2;
  localparam int CNT_W = $clog2(STEPS);

  logic [SH_W-1:0]  sh_a;
  logic [SH_W-1:0]  sh_b;
  logic [LOD_W-1:0] div_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [LOD_W-1:0] ra1;
  logic [LOD_W-1:0] ra2;
  logic [LOD_W-1:0] rb1;
  logic [LOD_W-1:0] rb2;

  // one restoring step: shift in a bit, subtract if it fits
  function automatic logic [LOD_W-1:0] rem_step(logic [LOD_W-1:0] r, logic b,
                                                logic [LOD_W-1:0] d);
    logic [LOD_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[LOD_W-1:0];
  endfunction

  // two bits per cycle
  always_comb begin
    ra1 = rem_step(rem_a, sh_a[SH_W-1], div_q);
    ra2 = rem_step(ra1, sh_a[SH_W-2], div_q);
    rb1 = rem_step(rem_b, sh_b[SH_W-1], div_q);
    rb2 = rem_step(rb1, sh_b[SH_W-2], div_q);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sh_a  <= {{(SH_W-COORD_W){1'b0}}, num_a};
      sh_b  <= {{(SH_W-COORD_W){1'b0}}, num_b};
      div_q <= divisor;
      rem_a <= '0;
      rem_b <= '0;
    end else if (busy) begin
      sh_a  <= {sh_a[SH_W-3:0], 2'b00};
      sh_b  <= {sh_b[SH_W-3:0], 2'b00};
      rem_a <= ra2;
      rem_b <= rb2;
    end
  end

endmodule

// ===== rtl/core/lgt_front.sv =====
// front end: accepts items, classifies cells, numbers map cells, forms map addresses
// uses lgt_pkg and lgt_mod
module lgt_front #(
  parameter int MESH_SIZE = 120
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        operation,
  input  logic [lgt_pkg::COORD_W-1:0] row,
  input  logic [lgt_pkg::COORD_W-1:0] col,
  input  logic [lgt_pkg::LOD_W-1:0]   step,
  input  logic                        q_full,
  output logic                        q_push,
  output lgt_pkg::cmd_t               q_din
);
  import lgt_pkg::*;

  localparam int GRID_N = MESH_SIZE + GRID_PAD;
  localparam logic [CMP_W-1:0] NC  = CMP_W'(GRID_N);
  localparam logic [CMP_W-1:0] NC1 = CMP_W'(GRID_N - 1);
  localparam logic [CMP_W-1:0] NC3 = CMP_W'(GRID_N - SKIP_MARGIN);
  localparam logic [CMP_W-1:0] ORG = CMP_W'(MAP_ORIGIN);
  localparam logic [CMP_W-1:0] MRG = CMP_W'(SKIP_MARGIN);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MOD  = 2'd1;
  localparam logic [1:0] F_HOLD = 2'd2;

  logic [1:0]         state;
  logic               op_q;
  logic [COORD_W-1:0] row_q;
  logic [COORD_W-1:0] col_q;
  addr_t              pos;
  addr_t              line_off;
  logic [BC_W-1:0]    bc;
  logic [MC_W-1:0]    mc;

  logic               accept;
  logic               mod_done;
  logic [LOD_W-1:0]   rr;
  logic [LOD_W-1:0]   rc;
  logic               decide;
  logic [CMP_W-1:0]   r8;
  logic [CMP_W-1:0]   c8;
  logic               in_grid;
  logic               border;
  logic               skip_area;
  logic               is_skip;
  logic               tri_range;
  logic               ring;
  logic               edge_cell;
  logic [LOD_W-1:0]   inc;
  logic               far;
  logic               tri_ok;
  logic               cmd_ok;
  logic               origin;
  logic [BC_W-1:0]    bc_use;
  logic [MC_W-1:0]    mc_use;
  addr_t              line_use;
  addr_t              addr_d;

  assign full   = (state != F_IDLE);
  assign accept = push && (state == F_IDLE);

  // offsets from the first mesh cell, modulo the lod step
  lgt_mod u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .num_a   (row - COORD_W'(MAP_ORIGIN)),
    .num_b   (col - COORD_W'(MAP_ORIGIN)),
    .divisor (step),
    .done    (mod_done),
    .rem_a   (rr),
    .rem_b   (rc)
  );

  // classification
  always_comb begin
    r8        = {1'b0, row_q};
    c8        = {1'b0, col_q};
    in_grid   = (r8 < NC) && (c8 < NC);
    border    = (r8 == '0) || (c8 == '0) || (r8 == NC1) || (c8 == NC1);
    skip_area = (r8 > ORG) && (r8 + MRG < NC) && (c8 > ORG) && (c8 + MRG < NC);
    is_skip   = skip_area && ((rr != '0) || (rc != '0));
    tri_range = (r8 != '0) && (c8 != '0) && (r8 <= NC3) && (c8 <= NC3);
    ring      = (r8 == CMP_W'(1)) || (c8 == CMP_W'(1)) || (r8 == NC3) || (c8 == NC3);
    edge_cell = ((r8 == ORG) && (rc != '0)) || ((c8 == ORG) && (rr != '0));
    inc       = ring ? LOD_W'(1) : step;
    far       = (r8 + CMP_W'(inc) > NC1) || (c8 + CMP_W'(inc) > NC1);
    tri_ok    = in_grid && tri_range && (ring || !(is_skip || edge_cell)) && !far;
    cmd_ok    = (op_q == OP_MAP) ? in_grid : tri_ok;
    decide    = ((state == F_MOD) && mod_done) || (state == F_HOLD);
    q_push    = decide && cmd_ok && !q_full;
  end

  // counters restart at the grid origin
  always_comb begin
    origin = (row_q == '0) && (col_q == '0);
    bc_use = origin ? '0 : bc;
    mc_use = origin ? '0 : mc;
  end

  // command assembly
  always_comb begin
    line_use = ring ? addr_t'(NC) : line_off;
    addr_d   = pos + line_use;
    q_din.is_tri = (op_q == OP_TRI);
    q_din.addr_a = pos;
    q_din.addr_b = pos + addr_t'(inc);
    q_din.addr_c = addr_d + addr_t'(inc);
    q_din.addr_d = addr_d;
    if (border) begin
      q_din.kind  = KIND_BORDER;
      q_din.wr    = 1'b1;
      q_din.value = {{(VAL_W-BC_W){1'b1}}, ~bc_use};
    end else if (!is_skip) begin
      q_din.kind  = KIND_MESH;
      q_din.wr    = 1'b1;
      q_din.value = {{(VAL_W-MC_W){1'b0}}, mc_use};
    end else begin
      q_din.kind  = KIND_SKIP;
      q_din.wr    = 1'b0;
      q_din.value = '0;
    end
  end

  // sequencer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      bc    <= '0;
      mc    <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            state <= F_MOD;
          end
        end
        F_MOD, F_HOLD: begin
          if (decide) begin
            if (!cmd_ok || !q_full) begin
              state <= F_IDLE;
            end else begin
              state <= F_HOLD;
            end
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
      if (q_push && (op_q == OP_MAP)) begin
        bc <= border ? bc_use + 1'b1 : bc_use;
        mc <= (!border && !is_skip) ? mc_use + 1'b1 : mc_use;
      end
    end
  end

  // item capture and linear position
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= operation;
      row_q <= row;
      col_q <= col;
    end
    if (state == F_MOD) begin
      pos      <= addr_t'(row_q) * addr_t'(NC) + addr_t'(col_q);
      line_off <= addr_t'(step) * addr_t'(NC);
    end
  end

endmodule

// ===== rtl/core/lgt_queue.sv =====
// two-entry command queue between the front end and the map engine
// uses lgt_pkg for the command type
module lgt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  lgt_pkg::cmd_t din,
  output logic          q_full,
  input  logic          rd,
  output lgt_pkg::cmd_t dout,
  output logic          q_empty
);
  import lgt_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW = $clog2(DEPTH);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0]   cnt;

  assign q_full  = (cnt == (PW+1)'(DEPTH));
  assign q_empty = (cnt == '0);
  assign dout    = slots[rp];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr) begin
        wp <= wp + 1'b1;
      end
      if (rd) begin
        rp <= rp + 1'b1;
      end
      if (wr && !rd) begin
        cnt <= cnt + 1'b1;
      end else if (rd && !wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= din;
    end
  end

endmodule

// ===== rtl/core/lgt_back.sv =====
// map engine: holds the index map, writes map cells, reads corners, emits results
// uses lgt_pkg and the assertion macros header
`include "lod_grid_triangle_index_generator_core_defines.svh"

module lgt_back #(
  parameter int MESH_SIZE = 120
) (
  input  logic          clk,
  input  logic          rst,
  input  lgt_pkg::cmd_t q_head,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output lgt_pkg::vidx_t vertex_index,
  output logic [1:0]    cell_kind,
  output logic          last
);
  import lgt_pkg::*;

  localparam int GRID_N = MESH_SIZE + GRID_PAD;
  localparam int DEPTH  = GRID_N * GRID_N;
  localparam int AW     = $clog2(DEPTH);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_TRI  = 1'b1;

  vidx_t   map_mem [DEPTH];
  vidx_t   val [4];
  addr_t   addr_q [4];
  logic    state;
  logic [2:0] rd_cnt;
  logic [2:0] em;
  logic [3:0] have;
  logic    out_valid;

  logic          out_free;
  logic          idle_take;
  logic          map_load;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [1:0]    rd_slot;
  logic [1:0]    sel;
  logic          emit;

  // corner order of the two triangles: a b c a c d
  function automatic logic [1:0] corner_of(logic [2:0] k);
    logic [1:0] s;
    case (k)
      3'd0: s = 2'd0;
      3'd1: s = 2'd1;
      3'd2: s = 2'd2;
      3'd3: s = 2'd0;
      3'd4: s = 2'd2;
      3'd5: s = 2'd3;
      default: s = 2'd0;
    endcase
    return s;
  endfunction

  assign empty = !out_valid;

  // command take, map access and emission control
  always_comb begin
    out_free  = !out_valid || pop;
    idle_take = (state == B_IDLE) && !q_empty && (q_head.is_tri || out_free);
    q_pop     = idle_take;
    map_load  = idle_take && !q_head.is_tri;
    wr_en     = map_load && q_head.wr;
    if (state == B_IDLE) begin
      rd_en   = idle_take && q_head.is_tri;
      rd_addr = q_head.addr_a[AW-1:0];
      rd_slot = 2'd0;
    end else begin
      rd_en   = !rd_cnt[2];
      rd_addr = addr_q[rd_cnt[1:0]][AW-1:0];
      rd_slot = rd_cnt[1:0];
    end
    sel  = corner_of(em);
    emit = (state == B_TRI) && have[sel] && out_free;
  end

  // index map, registered corner reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[q_head.addr_a[AW-1:0]] <= q_head.value;
    end
    if (rd_en) begin
      val[rd_slot] <= map_mem[rd_addr];
    end
  end

  // triangle sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= B_IDLE;
      rd_cnt <= '0;
      em     <= '0;
      have   <= '0;
    end else begin
      case (state)
        B_IDLE: begin
          if (idle_take && q_head.is_tri) begin
            state  <= B_TRI;
            rd_cnt <= 3'd1;
            em     <= '0;
            have   <= 4'b0001;
          end
        end
        B_TRI: begin
          if (rd_en) begin
            have[rd_slot] <= 1'b1;
            rd_cnt        <= rd_cnt + 1'b1;
          end
          if (emit) begin
            em <= em + 1'b1;
            if (em == 3'd5) begin
              state <= B_IDLE;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  // corner addresses of the current cell
  always_ff @(posedge clk) begin
    if (idle_take && q_head.is_tri) begin
      addr_q[0] <= q_head.addr_a;
      addr_q[1] <= q_head.addr_b;
      addr_q[2] <= q_head.addr_c;
      addr_q[3] <= q_head.addr_d;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (map_load || emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (map_load) begin
      vertex_index <= q_head.value;
      cell_kind    <= q_head.kind;
      last         <= 1'b1;
    end else if (emit) begin
      vertex_index <= val[sel];
      cell_kind    <= KIND_TRI;
      last         <= (em == 3'd5);
    end
  end

  // checks
  `LGT_ASSERT_IMP(a_wr_idle, wr_en, state == B_IDLE, "map write during corner reads")
  `LGT_ASSERT_IMP(a_emit_loaded, emit, have[sel], "corner emitted before its read")
  `LGT_ASSERT_NXT(a_tri_done, emit && (em == 3'd5), (state == B_IDLE) && last, "last corner not closing the cell")

endmodule

// ===== rtl/core/lod_grid_triangle_index_generator_core.sv =====
// Terrain grid index generator with queue-style ports on both sides (push/full in,
// empty/pop out). A map item (operation 0) inside the grid numbers one cell and
// yields one result; items must come in raster order, and both counters restart at
// cell (0,0). A triangle item (operation 1) yields six indices a,b,c,a,c,d or nothing.
// The front end takes a new item only once it is done with the last: a remainder
// unit (two bits per cycle) works out the cell's offsets modulo lod before the cell
// is classified. The map engine reads the four corners of a triangle item through
// the single read port of the index map; a two-entry queue between the two lets
// either side stall. The index map has no clearing pass: a triangle whose corners
// were never numbered returns undefined indices. Write lod only while idle.
//
// top level; uses lgt_pkg, lgt_front, lgt_queue and lgt_back
module lod_grid_triangle_index_generator_core #(
  parameter int MESH_SIZE = 120
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        operation,
  input  logic [lgt_pkg::COORD_W-1:0] row,
  input  logic [lgt_pkg::COORD_W-1:0] col,
  output logic                        empty,
  input  logic                        pop,
  output lgt_pkg::vidx_t              vertex_index,
  output logic [1:0]                  cell_kind,
  output logic                        last,
  input  logic                        lod_we,
  input  logic [lgt_pkg::LOD_W-1:0]   lod_wdata
);
  import lgt_pkg::*;

  logic [LOD_W-1:0] lod;
  logic [LOD_W-1:0] step;
  cmd_t             q_din;
  cmd_t             q_head;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;

  // lod register, zero acts as one
  always_ff @(posedge clk) begin
    if (rst) begin
      lod <= LOD_RESET;
    end else if (lod_we) begin
      lod <= lod_wdata;
    end
  end

  assign step = (lod == '0) ? LOD_W'(1) : lod;

  lgt_front #(
    .MESH_SIZE (MESH_SIZE)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .operation (operation),
    .row       (row),
    .col       (col),
    .step      (step),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  lgt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .din     (q_din),
    .q_full  (q_full),
    .rd      (q_pop),
    .dout    (q_head),
    .q_empty (q_empty)
  );

  lgt_back #(
    .MESH_SIZE (MESH_SIZE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_head       (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .vertex_index (vertex_index),
    .cell_kind    (cell_kind),
    .last         (last)
  );

endmodule

// ===== sim/tb_lod_grid_triangle_index_generator_core.sv =====
// testbench for the lod grid triangle index generator core
// needs lgt_pkg and the core rtl; self-checking, prints a pass or fail line at the end
module tb_lod_grid_triangle_index_generator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lgt_pkg::*;

  localparam int MESH_SIZE    = 120;
  localparam int GRID_N       = MESH_SIZE + GRID_PAD;
  localparam int MAP_CELLS    = GRID_N * GRID_N;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 27;
  localparam int HOLD_CYCLES  = 400;

  typedef struct packed {
    vidx_t      value;
    logic [1:0] kind;
    logic       fin;
  } index_result_t;

  // numbering state of the grid plus the indices still owed by the block
  class grid_numbering;
    logic [LOD_W-1:0] lod;
    logic [15:0]      map_words [MAP_CELLS];
    bit               stored [MAP_CELLS];
    logic [BC_W-1:0]  border_count;
    logic [MC_W-1:0]  mesh_count;
    index_result_t    pending_indices [$];
    int               mismatches;
    int               results_checked;
    int               map_items;
    int               tri_items;

    function new();
      lod = LOD_RESET;
      border_count = '0;
      mesh_count = '0;
      mismatches = 0;
      results_checked = 0;
      map_items = 0;
      tri_items = 0;
      foreach (stored[i]) stored[i] = 1'b0;
    endfunction

    function int step_size();
      return (lod == 0) ? 1 : int'(lod);
    endfunction

    function int pending();
      return pending_indices.size();
    endfunction

    function bit skipped(int r, int c, int s);
      return (r > MAP_ORIGIN && r + SKIP_MARGIN < GRID_N &&
              c > MAP_ORIGIN && c + SKIP_MARGIN < GRID_N) &&
             (((r - MAP_ORIGIN) % s) != 0 || ((c - MAP_ORIGIN) % s) != 0);
    endfunction

    // corner cells of the two triangles at (r,c); returns 0 when the cell gives none
    function bit quad_corners(int r, int c, output int pa, output int pb,
                              output int pc, output int pd);
      int s;
      int span;
      bit on_rim;
      s = step_size();
      span = 1;
      pa = 0;
      pb = 0;
      pc = 0;
      pd = 0;
      if (r < 1 || c < 1 || r > GRID_N - 3 || c > GRID_N - 3) return 1'b0;
      // ring next to the border spans one cell, interior spans the lod step
      if (!(r == 1 || c == 1 || r == GRID_N - 3 || c == GRID_N - 3)) begin
        on_rim = (r == MAP_ORIGIN && ((c - MAP_ORIGIN) % s) != 0) ||
                 (c == MAP_ORIGIN && ((r - MAP_ORIGIN) % s) != 0);
        if (skipped(r, c, s) || on_rim) return 1'b0;
        span = s;
      end
      if (r + span > GRID_N - 1 || c + span > GRID_N - 1) return 1'b0;
      pa = r * GRID_N + c;
      pb = pa + span;
      pc = (r + span) * GRID_N + c + span;
      pd = (r + span) * GRID_N + c;
      return 1'b1;
    endfunction

    // a triangle item may only read cells that were numbered before
    function bit can_send(bit op, int r, int c);
      int pa, pb, pc, pd;
      if (op == OP_MAP || !quad_corners(r, c, pa, pb, pc, pd)) return 1'b1;
      return stored[pa] && stored[pb] && stored[pc] && stored[pd];
    endfunction

    function void owe(logic [15:0] word, logic [1:0] kind, logic fin);
      index_result_t res;
      res.value = word[VAL_W-1:0];
      res.kind = kind;
      res.fin = fin;
      pending_indices.push_back(res);
    endfunction

    // update the numbering for one accepted item and queue what it yields
    function void note_item(bit op, int r, int c);
      int pa, pb, pc, pd;
      logic [15:0] word;
      if (op == OP_MAP) map_items++;
      else tri_items++;
      if (r >= GRID_N || c >= GRID_N) return;
      if (op == OP_MAP) begin
        pa = r * GRID_N + c;
        if (r == 0 && c == 0) begin
          border_count = '0;
          mesh_count = '0;
        end
        if (r == 0 || c == 0 || r == GRID_N - 1 || c == GRID_N - 1) begin
          word = 16'hFFFF - 16'(border_count);
          border_count = border_count + 1'b1;
          map_words[pa] = word;
          stored[pa] = 1'b1;
          owe(word, KIND_BORDER, 1'b1);
        end else if (!skipped(r, c, step_size())) begin
          word = 16'(mesh_count);
          mesh_count = mesh_count + 1'b1;
          map_words[pa] = word;
          stored[pa] = 1'b1;
          owe(word, KIND_MESH, 1'b1);
        end else begin
          owe(16'd0, KIND_SKIP, 1'b1);
        end
      end else if (quad_corners(r, c, pa, pb, pc, pd)) begin
        owe(map_words[pa], KIND_TRI, 1'b0);
        owe(map_words[pb], KIND_TRI, 1'b0);
        owe(map_words[pc], KIND_TRI, 1'b0);
        owe(map_words[pa], KIND_TRI, 1'b0);
        owe(map_words[pc], KIND_TRI, 1'b0);
        owe(map_words[pd], KIND_TRI, 1'b1);
      end
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 100) $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // compare one accepted result with the oldest owed index
    task check_result(vidx_t value, logic [1:0] kind, logic fin);
      index_result_t want;
      results_checked++;
      if (pending_indices.size() == 0) begin
        report_mismatch($sformatf("result %0d kind %0d with nothing owed",
                                  $signed(value), kind));
        return;
      end
      want = pending_indices.pop_front();
      if (value !== want.value)
        report_mismatch($sformatf("vertex_index %0d, want %0d", $signed(value),
                                  $signed(want.value)));
      if (kind !== want.kind)
        report_mismatch($sformatf("cell_kind %0d, want %0d", kind, want.kind));
      if (fin !== want.fin)
        report_mismatch($sformatf("last %0b, want %0b", fin, want.fin));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  logic                operation;
  logic [COORD_W-1:0]  row;
  logic [COORD_W-1:0]  col;
  logic                empty;
  logic                pop;
  vidx_t               vertex_index;
  logic [1:0]          cell_kind;
  logic                last;
  logic                lod_we;
  logic [LOD_W-1:0]    lod_wdata;

  grid_numbering sb;
  int            items_sent;
  int            lod_writes;

  lod_grid_triangle_index_generator_core #(
    .MESH_SIZE(MESH_SIZE)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .operation    (operation),
    .row          (row),
    .col          (col),
    .empty        (empty),
    .pop          (pop),
    .vertex_index (vertex_index),
    .cell_kind    (cell_kind),
    .last         (last),
    .lod_we       (lod_we),
    .lod_wdata    (lod_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // offer one item and hold it until the block takes it
  task automatic offer(bit op, int r, int c);
    if (!sb.can_send(op, r, c)) return;
    if (!(items_sent >= 60 && items_sent < 170) && $urandom_range(99) < 13) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push <= 1'b1;
    operation <= op;
    row <= r[COORD_W-1:0];
    col <= c[COORD_W-1:0];
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(op, r, c);
    items_sent++;
  endtask

  // lod changes only once every owed index is out and the pipe has drained
  task automatic write_lod(int v);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    lod_we <= 1'b1;
    lod_wdata <= v[LOD_W-1:0];
    @(posedge clk);
    lod_we <= 1'b0;
    sb.lod = v[LOD_W-1:0];
    lod_writes++;
  endtask

  // a small patch: mostly restart at (0,0), number the corners of a few quads, then ask for them
  task automatic run_patch();
    int cells [$];
    int quads [$];
    int s, m, r, c, t, pa, pb, pc, pd, prev;
    s = sb.step_size();
    m = (GRID_N - 4) / s;
    if ($urandom_range(4) != 0) cells.push_back(0);
    repeat ($urandom_range(1, 3)) begin
      t = $urandom_range(1, GRID_N - 3);
      case ($urandom_range(3))
        0: begin
          r = $urandom_range(1) ? 1 : GRID_N - 3;
          c = t;
          if ($urandom_range(1)) begin
            c = r;
            r = t;
          end
        end
        1: begin
          r = MAP_ORIGIN + s * $urandom_range(m);
          c = MAP_ORIGIN + s * $urandom_range(m);
        end
        2: begin
          r = MAP_ORIGIN;
          c = MAP_ORIGIN + s * $urandom_range(m);
          if ($urandom_range(1)) begin
            r = c;
            c = MAP_ORIGIN;
          end
        end
        default: begin
          r = t;
          c = $urandom_range(1, GRID_N - 3);
        end
      endcase
      quads.push_back(r * GRID_N + c);
      if (sb.quad_corners(r, c, pa, pb, pc, pd)) begin
        cells.push_back(pa);
        cells.push_back(pb);
        cells.push_back(pc);
        cells.push_back(pd);
      end else begin
        cells.push_back(r * GRID_N + c);
      end
    end
    repeat ($urandom_range(2)) cells.push_back($urandom_range(MAP_CELLS - 1));
    // mostly raster order, now and then scrambled
    if ($urandom_range(5) == 0) cells.shuffle();
    else cells.sort();
    prev = -1;
    foreach (cells[i]) begin
      if (cells[i] != prev) offer(OP_MAP, cells[i] / GRID_N, cells[i] % GRID_N);
      prev = cells[i];
    end
    if ($urandom_range(7) == 0) offer(OP_MAP, $urandom_range(GRID_N, 127), $urandom_range(127));
    foreach (quads[i]) offer(OP_TRI, quads[i] / GRID_N, quads[i] % GRID_N);
    repeat ($urandom_range(2))
      offer(1'($urandom_range(1)), $urandom_range(127), $urandom_range(127));
  endtask

  // result side: random pops, one long hold-off so the block backs up
  initial begin : result_side
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    pop = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check_result(vertex_index, cell_kind, last);
      if (!held && sb.results_checked >= 40) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else if (!(sb.results_checked >= 90 && sb.results_checked < 230) &&
                   $urandom_range(99) < 13) begin
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles in which no item moves on either side
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // stimulus
  initial begin : stimulus
    int phase_lods [12];
    int start;
    sb = new();
    items_sent = 0;
    lod_writes = 0;
    rst = 1'b1;
    push = 1'b0;
    operation = 1'b0;
    row = '0;
    col = '0;
    lod_we = 1'b0;
    lod_wdata = '0;
    phase_lods = '{2, 6, 12, 1, 0, 7, 15, 4, 12, 3, 1, 6};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: corners of the grid, the first and last ring quads, outside and out-of-range cells
    write_lod(1);
    offer(OP_MAP, 0, 0);
    offer(OP_MAP, 0, GRID_N - 1);
    offer(OP_MAP, GRID_N - 1, 0);
    offer(OP_MAP, GRID_N - 1, GRID_N - 1);
    offer(OP_MAP, 1, 1);
    offer(OP_MAP, 1, 2);
    offer(OP_MAP, 2, 1);
    offer(OP_MAP, 2, 2);
    offer(OP_TRI, 1, 1);
    offer(OP_MAP, 127, 127);
    offer(OP_MAP, GRID_N, 3);
    offer(OP_TRI, 3, GRID_N);
    offer(OP_TRI, 0, 5);
    offer(OP_TRI, GRID_N - 2, GRID_N - 2);
    offer(OP_MAP, GRID_N - 3, GRID_N - 3);
    offer(OP_MAP, GRID_N - 3, GRID_N - 2);
    offer(OP_MAP, GRID_N - 2, GRID_N - 3);
    offer(OP_MAP, GRID_N - 2, GRID_N - 2);
    offer(OP_TRI, GRID_N - 3, GRID_N - 3);
    // skipped cell and rim cell at lod 2
    write_lod(2);
    offer(OP_MAP, 3, 3);
    offer(OP_TRI, 3, 3);
    offer(OP_TRI, 2, 3);
    // far corner falls outside when lod does not divide the mesh
    write_lod(7);
    offer(OP_TRI, 121, 121);
    // lod zero behaves as lod one
    write_lod(0);
    offer(OP_MAP, 2, 3);
    offer(OP_MAP, 3, 2);
    offer(OP_MAP, 3, 3);
    offer(OP_TRI, 2, 2);

    // random patches over several lod settings
    foreach (phase_lods[i]) begin
      write_lod(phase_lods[i]);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) run_patch();
    end

    // drain
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d items (%0d map, %0d triangle) across %0d lod writes, 0 to 15",
             items_sent, sb.map_items, sb.tri_items, lod_writes);
    $display("checked %0d results under random idling and a long output stall; %0d mismatches",
             sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lgt_pkg.sv
rtl/core/lgt_mod.sv
rtl/core/lgt_front.sv
rtl/core/lgt_queue.sv
rtl/core/lgt_back.sv
rtl/core/lod_grid_triangle_index_generator_core.sv
sim/tb_lod_grid_triangle_index_generator_core.sv
